### rtl/core/bmp_rle8_row_decoder_top_assert.svh
// Assertion macros for the BMP RLE8 row decoder.
// Used by bmp_rle8_row_decoder_top; expects clk_i and rst_ni in scope.
`ifndef BMP_RLE8_ROW_DECODER_TOP_ASSERT_SVH
`define BMP_RLE8_ROW_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BMPRLE8_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BMPRLE8_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/bmprle8_pkg.sv
// Shared types and constants for the BMP RLE8 row decoder.
// No dependencies; imported by bmp_rle8_row_decoder_top and its testbench.
package bmprle8_pkg;

  // Size limits and field widths.
  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned CFG_W      = 13;
  localparam int unsigned POS_W      = 13;
  localparam int unsigned X_W        = 12;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned IDX_W      = 2;

  // Register reset values.
  localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(480);
  localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(320);

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] CFG_IDX_WIDTH  = IDX_W'(0);
  localparam logic [IDX_W-1:0] CFG_IDX_HEIGHT = IDX_W'(1);

  // Input beat action codes.
  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_DATA  = 2'd1,
    ACT_END   = 2'd2
  } action_e;

  // Stream parser phase.
  typedef enum logic [2:0] {
    PH_DONE = 3'd0,
    PH_CMD1 = 3'd1,
    PH_CMD2 = 3'd2,
    PH_DX   = 3'd3,
    PH_DY   = 3'd4,
    PH_LIT  = 3'd5,
    PH_PAD  = 3'd6
  } phase_e;

  // Second byte of an escape command.
  localparam logic [BYTE_W-1:0] ESC_EOL   = BYTE_W'(0);
  localparam logic [BYTE_W-1:0] ESC_EOB   = BYTE_W'(1);
  localparam logic [BYTE_W-1:0] ESC_DELTA = BYTE_W'(2);

  // One result beat.
  typedef struct packed {
    logic              span_valid;
    logic [X_W-1:0]    span_x;
    logic [BYTE_W-1:0] span_length;
    logic [BYTE_W-1:0] pixel_value;
    logic              row_done;
    logic              image_done;
    logic              stream_error;
  } result_t;

endpackage

### rtl/core/bmp_rle8_row_decoder_top.sv
// Top level of the BMP RLE8 row decoder: parser, position tracking, output buffer.
// Depends on bmprle8_pkg and bmp_rle8_row_decoder_top_assert.svh.
//
// Usage:
// The input channel (in_valid_i / in_stall_o) carries one beat per stream
// byte: action_i selects start of image, data byte or end of stream, and
// data_byte_i holds the compressed byte. Each accepted beat produces zero or
// one result beat on the output channel (out_valid_o / out_stall_i): a pixel
// span within the current row, plus row done, image done and stream error
// flags. Beats that only advance the parser produce no result.
// Each result goes to the result register when it is empty or being taken,
// else to the skid register. Throughput is one byte per cycle while in_stall_o
// is low; the parser state registers update on each accepted beat.
// The output side has a result register and a one-entry skid register, so an
// input beat is still taken while a result waits; in_stall_o rises only once
// the skid entry is occupied and falls when the receiver takes a result.
// Configuration writes (cfg_valid_i / cfg_ready_o) set the image width and
// height; the user must issue them only while the decoder is idle, which the
// block does not enforce. Reset sets width 480 and height 320 and leaves the
// parser stopped until a start beat arrives; bytes before it are ignored.
`include "bmp_rle8_row_decoder_top_assert.svh"

module bmp_rle8_row_decoder_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bmprle8_pkg::IDX_W-1:0]   cfg_index_i,
  input  logic [bmprle8_pkg::CFG_W-1:0]   cfg_data_i,
  // Input byte channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      action_i,
  input  logic [bmprle8_pkg::BYTE_W-1:0]  data_byte_i,
  // Result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            span_valid_o,
  output logic [bmprle8_pkg::X_W-1:0]     span_x_o,
  output logic [bmprle8_pkg::BYTE_W-1:0]  span_length_o,
  output logic [bmprle8_pkg::BYTE_W-1:0]  pixel_value_o,
  output logic                            row_done_o,
  output logic                            image_done_o,
  output logic                            stream_error_o
);
  import bmprle8_pkg::*;

  // Configuration registers.
  logic [CFG_W-1:0] width_q, height_q;

  // Parser state.
  phase_e            phase_q, phase_d;
  logic [BYTE_W-1:0] first_q, first_d;
  logic [BYTE_W-1:0] dx_q, dx_d;
  logic [BYTE_W-1:0] lit_q, lit_d;
  logic              pad_q, pad_d;
  logic [POS_W-1:0]  col_q, col_d;
  logic [POS_W-1:0]  line_q, line_d;

  // Output buffer.
  result_t out_q, skid_q, res;
  logic    out_valid_q, skid_valid_q;

  // Working values.
  logic [POS_W-1:0]  eff_w, eff_h;
  logic [POS_W:0]    run_sum, dx_sum, line_sum;
  logic [POS_W-1:0]  col_room;
  logic [BYTE_W-1:0] run_len;
  logic              row_chk;
  logic              res_valid, in_accept, out_pop, res_push;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_IDX_WIDTH) begin
        width_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_IDX_HEIGHT) begin
        height_q <= cfg_data_i;
      end
    end
  end

  // Effective sizes: zero acts as one, and values are capped at the maximum.
  always_comb begin
    if (width_q == '0) begin
      eff_w = POS_W'(1);
    end else if (width_q > CFG_W'(MAX_WIDTH)) begin
      eff_w = POS_W'(MAX_WIDTH);
    end else begin
      eff_w = width_q;
    end
    if (height_q == '0) begin
      eff_h = POS_W'(1);
    end else if (height_q > CFG_W'(MAX_HEIGHT)) begin
      eff_h = POS_W'(MAX_HEIGHT);
    end else begin
      eff_h = height_q;
    end
  end

  // Shared arithmetic for runs and deltas.
  assign run_sum  = {1'b0, col_q} + {{(POS_W+1-BYTE_W){1'b0}}, first_q};
  assign dx_sum   = {1'b0, col_q} + {{(POS_W+1-BYTE_W){1'b0}}, dx_q};
  assign line_sum = {1'b0, line_q} + {{(POS_W+1-BYTE_W){1'b0}}, data_byte_i};
  assign col_room = eff_w - col_q;
  assign run_len  = (col_room > POS_W'(first_q)) ? first_q : col_room[BYTE_W-1:0];

  // Next parser state and the result for the current input beat.
  always_comb begin
    phase_d = phase_q;
    first_d = first_q;
    dx_d    = dx_q;
    lit_d   = lit_q;
    pad_d   = pad_q;
    col_d   = col_q;
    line_d  = line_q;
    res     = '0;
    row_chk = 1'b0;

    case (action_i)
      ACT_START: begin
        col_d   = '0;
        line_d  = '0;
        first_d = '0;
        dx_d    = '0;
        lit_d   = '0;
        pad_d   = 1'b0;
        phase_d = PH_CMD1;
      end
      ACT_END: begin
        if (phase_q != PH_DONE) begin
          res.stream_error = 1'b1;
          phase_d          = PH_DONE;
        end
      end
      ACT_DATA: begin
        unique case (phase_q)
          PH_CMD1: begin
            first_d = data_byte_i;
            phase_d = PH_CMD2;
          end
          PH_CMD2: begin
            if (first_q != '0) begin
              // Encoded run, clipped to the row.
              if (col_q < eff_w) begin
                res.span_valid  = 1'b1;
                res.span_x      = col_q[X_W-1:0];
                res.span_length = run_len;
                res.pixel_value = data_byte_i;
              end
              col_d   = (run_sum > {1'b0, eff_w}) ? eff_w : run_sum[POS_W-1:0];
              phase_d = PH_CMD1;
              row_chk = 1'b1;
            end else if (data_byte_i == ESC_EOL) begin
              col_d   = eff_w;
              phase_d = PH_CMD1;
              row_chk = 1'b1;
            end else if (data_byte_i == ESC_EOB) begin
              res.image_done = 1'b1;
              phase_d        = PH_DONE;
            end else if (data_byte_i == ESC_DELTA) begin
              phase_d = PH_DX;
            end else begin
              // Absolute mode; odd counts are followed by a pad byte.
              lit_d   = data_byte_i;
              pad_d   = data_byte_i[0];
              phase_d = PH_LIT;
            end
          end
          PH_DX: begin
            dx_d    = data_byte_i;
            phase_d = PH_DY;
          end
          PH_DY: begin
            col_d   = (dx_sum >= {1'b0, eff_w}) ? (eff_w - POS_W'(1)) : dx_sum[POS_W-1:0];
            line_d  = line_sum[POS_W-1:0];
            phase_d = PH_CMD1;
            if (line_sum >= {1'b0, eff_h}) begin
              res.image_done = 1'b1;
              phase_d        = PH_DONE;
            end
          end
          PH_LIT: begin
            if (col_q < eff_w) begin
              res.span_valid  = 1'b1;
              res.span_x      = col_q[X_W-1:0];
              res.span_length = BYTE_W'(1);
              res.pixel_value = data_byte_i;
              col_d           = col_q + POS_W'(1);
            end
            if (lit_q != '0) begin
              lit_d = lit_q - BYTE_W'(1);
            end
            if (lit_d == '0) begin
              if (pad_q) begin
                phase_d = PH_PAD;
              end else begin
                phase_d = PH_CMD1;
                row_chk = 1'b1;
              end
            end
          end
          PH_PAD: begin
            pad_d   = 1'b0;
            phase_d = PH_CMD1;
            row_chk = 1'b1;
          end
          PH_DONE: begin
            // Bytes are ignored while stopped.
          end
          default: begin
            phase_d = PH_DONE;
          end
        endcase
      end
      default: begin
        // Unused action code: no effect.
      end
    endcase

    // Row completion once the column reaches the width.
    if (row_chk && (col_d >= eff_w)) begin
      res.row_done = 1'b1;
      col_d        = '0;
      line_d       = line_q + POS_W'(1);
      if (line_d >= eff_h) begin
        res.image_done = 1'b1;
        phase_d        = PH_DONE;
      end
    end
  end

  assign res_valid = res.span_valid | res.row_done | res.image_done | res.stream_error;

  // Handshakes: input is held off only while the skid entry is full.
  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_pop    = out_valid_q && !out_stall_i;
  assign res_push   = in_accept && res_valid;

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_DONE;
      first_q <= '0;
      dx_q    <= '0;
      lit_q   <= '0;
      pad_q   <= 1'b0;
      col_q   <= '0;
      line_q  <= '0;
    end else if (in_accept) begin
      phase_q <= phase_d;
      first_q <= first_d;
      dx_q    <= dx_d;
      lit_q   <= lit_d;
      pad_q   <= pad_d;
      col_q   <= col_d;
      line_q  <= line_d;
    end
  end

  // Output buffer occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (res_push) begin
      if (!out_valid_q || out_pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_pop) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output buffer payload.
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_pop) begin
        out_q <= skid_q;
      end
    end else if (res_push) begin
      if (!out_valid_q || out_pop) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign span_valid_o   = out_q.span_valid;
  assign span_x_o       = out_q.span_x;
  assign span_length_o  = out_q.span_length;
  assign pixel_value_o  = out_q.pixel_value;
  assign row_done_o     = out_q.row_done;
  assign image_done_o   = out_q.image_done;
  assign stream_error_o = out_q.stream_error;

  // Checks on the buffer and the position tracking.
  `BMPRLE8_ASSERT_NOW(a_skid_needs_out, skid_valid_q, out_valid_q, "skid entry without result")
  `BMPRLE8_ASSERT_NOW(a_result_not_empty, out_valid_q, (out_q.span_valid || out_q.row_done || out_q.image_done || out_q.stream_error), "empty result beat")
  `BMPRLE8_ASSERT_NOW(a_span_nonzero, out_valid_q && out_q.span_valid, out_q.span_length != '0, "zero length span")
  `BMPRLE8_ASSERT_NEXT(a_stalled_push_skids, out_valid_q && out_stall_i && res_push, skid_valid_q, "result lost while stalled")
  `BMPRLE8_ASSERT_NOW(a_col_bounded, 1'b1, col_q <= POS_W'(MAX_WIDTH), "column beyond maximum width")

endmodule

### tb/bmp_rle8_row_decoder_top_tb.sv
// Self-checking testbench for bmp_rle8_row_decoder_top: directed and random RLE8 byte streams.
// A scoreboard class predicts span, row, image and error beats and checks them in order.
// Depends on bmprle8_pkg and the RTL of bmp_rle8_row_decoder_top.
module bmp_rle8_row_decoder_top_tb;
  import bmprle8_pkg::*;

  // Action code that the decoder ignores, and the lead byte of an escape command.
  localparam logic [1:0]        ACT_NONE          = 2'd3;
  localparam logic [BYTE_W-1:0] ESC_LEAD          = 8'h00;
  localparam int unsigned       CYCLE_LIMIT       = 1_000_000;
  localparam int unsigned       SETTLE_CYCLES     = 4;
  localparam int unsigned       BEATS_PER_SETTING = 70;
  localparam int unsigned       NUM_SETTINGS      = 12;

  // Scoreboard: tracks the parser position and queues the beats each byte should cause.
  class rle8_span_scoreboard;
    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;
    phase_e            phase;
    logic [BYTE_W-1:0] run_count;
    logic [BYTE_W-1:0] dx_hold;
    logic [BYTE_W-1:0] lit_left;
    logic              pad_pending;
    int unsigned       col_pos;
    int unsigned       row_pos;
    result_t           expected_q[$];
    int unsigned       errors;

    function new();
      width_reg   = WIDTH_RST;
      height_reg  = HEIGHT_RST;
      phase       = PH_DONE;
      run_count   = '0;
      dx_hold     = '0;
      lit_left    = '0;
      pad_pending = 1'b0;
      col_pos     = 0;
      row_pos     = 0;
      errors      = 0;
    endfunction

    // Out-of-range sizes act as the nearest legal size.
    function int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      if (height_reg == 0) return 1;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return height_reg;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      if (idx == CFG_IDX_WIDTH) width_reg = value;
      else if (idx == CFG_IDX_HEIGHT) height_reg = value;
    endfunction

    // A full row wraps to the next one; the last row ends the image.
    function void close_row(inout result_t r, input int unsigned w);
      if (col_pos >= w) begin
        r.row_done = 1'b1;
        col_pos = 0;
        row_pos++;
        if (row_pos >= eff_height()) begin
          r.image_done = 1'b1;
          phase = PH_DONE;
        end
      end
    endfunction

    // Advances the parser by one accepted input beat.
    function void note_beat(logic [1:0] act, logic [BYTE_W-1:0] b);
      result_t     r;
      int unsigned w;
      int unsigned len;
      r = '0;
      w = eff_width();
      if (act == ACT_START) begin
        col_pos     = 0;
        row_pos     = 0;
        run_count   = '0;
        dx_hold     = '0;
        lit_left    = '0;
        pad_pending = 1'b0;
        phase       = PH_CMD1;
      end else if (act == ACT_END) begin
        if (phase != PH_DONE) begin
          r.stream_error = 1'b1;
          phase = PH_DONE;
        end
      end else if (act == ACT_DATA) begin
        case (phase)
          PH_CMD1: begin
            run_count = b;
            phase = PH_CMD2;
          end
          PH_CMD2: begin
            if (run_count != 0) begin
              // Encoded run, clipped at the right edge.
              len = (col_pos < w) ? w - col_pos : 0;
              if (len > run_count) len = run_count;
              if (len != 0) begin
                r.span_valid  = 1'b1;
                r.span_x      = X_W'(col_pos);
                r.span_length = BYTE_W'(len);
                r.pixel_value = b;
              end
              col_pos += run_count;
              if (col_pos > w) col_pos = w;
              phase = PH_CMD1;
              close_row(r, w);
            end else if (b == ESC_EOL) begin
              phase = PH_CMD1;
              col_pos = w;
              close_row(r, w);
            end else if (b == ESC_EOB) begin
              r.image_done = 1'b1;
              phase = PH_DONE;
            end else if (b == ESC_DELTA) begin
              phase = PH_DX;
            end else begin
              lit_left    = b;
              pad_pending = b[0];
              phase       = PH_LIT;
            end
          end
          PH_DX: begin
            dx_hold = b;
            phase = PH_DY;
          end
          PH_DY: begin
            col_pos += dx_hold;
            if (col_pos >= w) col_pos = w - 1;
            row_pos += b;
            phase = PH_CMD1;
            if (row_pos >= eff_height()) begin
              r.image_done = 1'b1;
              phase = PH_DONE;
            end
          end
          PH_LIT: begin
            // Literal pixels past the right edge are consumed silently.
            if (col_pos < w) begin
              r.span_valid  = 1'b1;
              r.span_x      = X_W'(col_pos);
              r.span_length = BYTE_W'(1);
              r.pixel_value = b;
              col_pos++;
            end
            if (lit_left != 0) lit_left--;
            if (lit_left == 0) begin
              if (pad_pending) begin
                phase = PH_PAD;
              end else begin
                phase = PH_CMD1;
                close_row(r, w);
              end
            end
          end
          PH_PAD: begin
            pad_pending = 1'b0;
            phase = PH_CMD1;
            close_row(r, w);
          end
          default: ;
        endcase
      end
      if (r.span_valid || r.row_done || r.image_done || r.stream_error) begin
        expected_q.push_back(r);
      end
    endfunction

    function void compare_field(string field, logic [X_W-1:0] want, logic [X_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    // Checks one accepted result beat against the oldest expectation.
    function void check_beat(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result beat with nothing expected, expected none, got %h", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("span_valid", X_W'(want.span_valid), X_W'(got.span_valid));
      compare_field("span_x", want.span_x, got.span_x);
      compare_field("span_length", X_W'(want.span_length), X_W'(got.span_length));
      compare_field("pixel_value", X_W'(want.pixel_value), X_W'(got.pixel_value));
      compare_field("row_done", X_W'(want.row_done), X_W'(got.row_done));
      compare_field("image_done", X_W'(want.image_done), X_W'(got.image_done));
      compare_field("stream_error", X_W'(want.stream_error), X_W'(got.stream_error));
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [IDX_W-1:0]  cfg_index_i;
  logic [CFG_W-1:0]  cfg_data_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [1:0]        action_i;
  logic [BYTE_W-1:0] data_byte_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic              span_valid_o;
  logic [X_W-1:0]    span_x_o;
  logic [BYTE_W-1:0] span_length_o;
  logic [BYTE_W-1:0] pixel_value_o;
  logic              row_done_o;
  logic              image_done_o;
  logic              stream_error_o;

  rle8_span_scoreboard sb;
  result_t             got_beat;
  int unsigned         live_items = 0;
  int unsigned         cycle_count = 0;
  bit                  in_burst = 1'b0;

  bmp_rle8_row_decoder_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .span_valid_o   (span_valid_o),
    .span_x_o       (span_x_o),
    .span_length_o  (span_length_o),
    .pixel_value_o  (pixel_value_o),
    .row_done_o     (row_done_o),
    .image_done_o   (image_done_o),
    .stream_error_o (stream_error_o)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result monitor: every accepted result beat goes to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o && !out_stall_i) begin
      got_beat.span_valid   = span_valid_o;
      got_beat.span_x       = span_x_o;
      got_beat.span_length  = span_length_o;
      got_beat.pixel_value  = pixel_value_o;
      got_beat.row_done     = row_done_o;
      got_beat.image_done   = image_done_o;
      got_beat.stream_error = stream_error_o;
      sb.check_beat(got_beat);
    end
  end

  // Receiver stalls: mostly short, a few long, with mostly short free stretches between and now and then a long one.
  initial begin : out_stall_gen
    int unsigned pick;
    int unsigned hold;
    int unsigned free_run;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      pick = $urandom_range(0, 99);
      if (pick < 50) hold = 0;
      else if (pick < 80) hold = $urandom_range(1, 2);
      else if (pick < 95) hold = $urandom_range(5, 15);
      else hold = $urandom_range(20, 40);
      free_run = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 4) : $urandom_range(20, 60);
      if (hold != 0) begin
        @(negedge clk_i);
        out_stall_i = 1'b1;
        repeat (hold - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_stall_i = 1'b0;
      repeat (free_run - 1) @(negedge clk_i);
    end
  end

  // Sends one input beat after an optional gap and waits until it is taken.
  task automatic send_beat(input logic [1:0] act, input logic [BYTE_W-1:0] b);
    int unsigned pick;
    int unsigned gap;
    gap = 0;
    if (!in_burst) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) gap = 0;
      else if (pick < 88) gap = $urandom_range(1, 3);
      else if (pick < 97) gap = $urandom_range(4, 10);
      else gap = $urandom_range(11, 30);
    end
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i  = 1'b1;
    action_i    = act;
    data_byte_i = b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (act == ACT_START || sb.phase != PH_DONE) live_items++;
    sb.note_beat(act, b);
  endtask

  // Drops valid and waits until every expected beat has come out.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, value);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // One random command, mostly well formed, sometimes cut short or pure noise.
  task automatic send_command();
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      n = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 12) : $urandom_range(13, 255);
      send_beat(ACT_DATA, BYTE_W'(n));
      send_beat(ACT_DATA, BYTE_W'($urandom));
    end else if (pick < 65) begin
      n = ($urandom_range(0, 9) != 0) ? $urandom_range(3, 12) : $urandom_range(13, 255);
      send_beat(ACT_DATA, ESC_LEAD);
      send_beat(ACT_DATA, BYTE_W'(n));
      repeat (n) send_beat(ACT_DATA, BYTE_W'($urandom));
      if (n[0]) send_beat(ACT_DATA, BYTE_W'($urandom));
    end else if (pick < 75) begin
      send_beat(ACT_DATA, ESC_LEAD);
      send_beat(ACT_DATA, ESC_EOL);
    end else if (pick < 85) begin
      send_beat(ACT_DATA, ESC_LEAD);
      send_beat(ACT_DATA, ESC_DELTA);
      send_beat(ACT_DATA, ($urandom_range(0, 3) != 0) ? BYTE_W'($urandom_range(0, 8))
                                                      : BYTE_W'($urandom));
      send_beat(ACT_DATA, ($urandom_range(0, 4) != 0) ? BYTE_W'($urandom_range(0, 1))
                                                      : BYTE_W'($urandom_range(2, 255)));
    end else if (pick < 88) begin
      send_beat(ACT_DATA, ESC_LEAD);
      send_beat(ACT_DATA, ESC_EOB);
    end else if (pick < 94) begin
      // Command broken off by an end of stream or a restart.
      send_beat(ACT_DATA, ($urandom_range(0, 1) != 0) ? ESC_LEAD : BYTE_W'($urandom));
      repeat ($urandom_range(0, 3)) send_beat(ACT_DATA, BYTE_W'($urandom));
      send_beat(($urandom_range(0, 1) != 0) ? ACT_END : ACT_START, BYTE_W'($urandom));
    end else begin
      send_beat(2'($urandom_range(0, 3)), BYTE_W'($urandom));
    end
  endtask

  // Random traffic for one register setting; may carry on the image left open.
  task automatic run_setting(input int unsigned budget);
    int unsigned target;
    target = live_items + budget;
    if (sb.phase == PH_DONE || $urandom_range(0, 3) == 0) begin
      send_beat(ACT_START, BYTE_W'($urandom));
    end
    while (live_items < target) begin
      if (sb.phase == PH_DONE) begin
        if ($urandom_range(0, 2) == 0) send_beat(ACT_DATA, BYTE_W'($urandom));
        if ($urandom_range(0, 3) == 0) send_beat(ACT_END, BYTE_W'($urandom));
        send_beat(ACT_START, BYTE_W'($urandom));
      end else begin
        send_command();
      end
    end
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] set_width[NUM_SETTINGS];
    logic [CFG_W-1:0] set_height[NUM_SETTINGS];
    sb          = new();
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_IDX_WIDTH;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    action_i    = ACT_DATA;
    data_byte_i = '0;

    // Fixed corner settings first, then small random images.
    set_width[0] = 16;    set_height[0] = 4;
    set_width[1] = 1;     set_height[1] = 1;
    set_width[2] = 0;     set_height[2] = 0;
    set_width[3] = 4096;  set_height[3] = 4096;
    set_width[4] = 8191;  set_height[4] = 8191;
    set_width[5] = 200;   set_height[5] = 3;
    for (int i = 6; i < NUM_SETTINGS; i++) begin
      set_width[i]  = CFG_W'($urandom_range(1, 40));
      set_height[i] = CFG_W'($urandom_range(1, 8));
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed stream at the reset size of 480 by 320.
    send_beat(ACT_DATA, 8'hFF);             // ignored before any start
    send_beat(ACT_END, 8'h00);              // ignored before any start
    send_beat(ACT_START, 8'h00);
    send_beat(ACT_DATA, 8'hFF);             // longest run at column zero
    send_beat(ACT_DATA, 8'hAA);
    send_beat(ACT_DATA, 8'hFF);             // run clipped at the right edge
    send_beat(ACT_DATA, 8'h55);
    send_beat(ACT_DATA, ESC_LEAD);          // odd literal followed by its pad byte
    send_beat(ACT_DATA, 8'h03);
    send_beat(ACT_DATA, 8'h01);
    send_beat(ACT_DATA, 8'h02);
    send_beat(ACT_DATA, 8'hFE);
    send_beat(ACT_DATA, 8'h7F);
    send_beat(ACT_DATA, ESC_LEAD);          // delta with the largest step right
    send_beat(ACT_DATA, ESC_DELTA);
    send_beat(ACT_DATA, 8'hFF);
    send_beat(ACT_DATA, 8'h01);
    send_beat(ACT_DATA, ESC_LEAD);
    send_beat(ACT_DATA, ESC_EOL);
    send_beat(ACT_DATA, ESC_LEAD);
    send_beat(ACT_DATA, ESC_EOB);
    send_beat(ACT_DATA, 8'h80);             // ignored after the image ends
    send_beat(ACT_START, 8'h00);
    send_beat(ACT_DATA, 8'h05);
    send_beat(ACT_END, 8'h00);              // stream cut inside a command
    send_beat(ACT_NONE, 8'hC3);

    // Random phases, each under its own register setting.
    for (int p = 0; p < NUM_SETTINGS; p++) begin
      settle();
      cfg_write(CFG_IDX_WIDTH, set_width[p]);
      cfg_write(CFG_IDX_HEIGHT, set_height[p]);
      in_burst = ($urandom_range(0, 3) == 0);
      run_setting(BEATS_PER_SETTING);
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### bmp_rle8_row_decoder_top.f
+incdir+rtl/core
rtl/core/bmprle8_pkg.sv
rtl/core/bmp_rle8_row_decoder_top.sv
tb/bmp_rle8_row_decoder_top_tb.sv
